// ----- rtl/core/cst_pkg.sv -----
package cst_pkg;

    localparam int CST_LENGTH_BITS = 16;
    localparam int CST_OFFSET_BITS = 32;

    localparam int RES_DEPTH = 3;

    typedef enum logic [2:0] {
        KIND_END       = 3'd0,
        KIND_INVALID   = 3'd1,
        KIND_DONT_CARE = 3'd2,
        KIND_NEWLINE   = 3'd3,
        KIND_COMMENT   = 3'd4,
        KIND_LITERAL   = 3'd5,
        KIND_INTEGER   = 3'd6,
        KIND_SYMBOL    = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_COMMENT = 5'b00010,
        MODE_LITERAL = 5'b00100,
        MODE_SYMBOL  = 5'b01000,
        MODE_RUN     = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       load;
        logic [1:0] count;
    } push_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_US    = 8'h5F;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic sym_first(input logic [7:0] c);
        return c[7] || is_alpha(c) || (c == CH_US);
    endfunction

    function automatic logic sym_more(input logic [7:0] c);
        return sym_first(c) || is_digit(c);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic in_run(input logic [7:0] c);
        logic hit;
        unique case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h2C, 8'h3B, 8'h25, 8'h3E,
            8'h3C, 8'h3D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D: hit = 1'b1;
            default: hit = is_digit(c);
        endcase
        return hit;
    endfunction

endpackage

// ----- rtl/core/cst_res_buf.sv -----
module cst_res_buf #(
    parameter int TOK_W = 52
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cst_pkg::push_t         push,
    input  logic [3*TOK_W-1:0]     push_tok,
    output logic                   can_load,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [TOK_W-1:0]       out_tok,
    output logic                   out_last
);
    import cst_pkg::*;

    logic [TOK_W-1:0] slot_reg [RES_DEPTH];
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             pop;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_tok   = slot_reg[0];
    assign out_last  = (cnt_reg == 2'd1);

    always_comb begin
        if (push.load) begin
            cnt_next = push.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
        end else begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // shift toward slot 0 on each beat
    always_ff @(posedge aclk) begin
        if (push.load) begin
            slot_reg[0] <= push_tok[TOK_W-1:0];
            slot_reg[1] <= push_tok[2*TOK_W-1:TOK_W];
            slot_reg[2] <= push_tok[3*TOK_W-1:2*TOK_W];
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

endmodule

// ----- rtl/core/c_source_tokenizer_unit.sv -----
// C source tokenizer: takes one byte of C text per s_ beat (s_tdata[7:0] the byte, s_tlast on
// the final byte) and returns tokens on the m_ side, each with kind, start offset, length
// and a directive-end flag; m_tlast marks the last token caused by a byte. Each byte is
// scanned in the cycle it is accepted and its zero to three tokens land in a three-entry
// result buffer that drains one token per beat. A byte is taken every cycle while each byte
// yields at most one token and the m_ side is ready; a byte that yields more tokens holds the
// input until its last token is being taken, since the m_ side carries one token per beat. A
// final byte always yields an end token and returns the scanner to its reset state.
module c_source_tokenizer_unit #(
    parameter int LENGTH_BITS = cst_pkg::CST_LENGTH_BITS,
    parameter int OFFSET_BITS = cst_pkg::CST_OFFSET_BITS
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic [7:0] s_tdata,   // text_byte
    input  logic s_tvalid,
    output logic s_tready,
    input  logic s_tlast,         // end_of_text
    // start_offset, token_length, zero fill
    output logic [((OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0] m_tdata,
    output logic [3:0] m_tuser,   // token_kind[2:0], ends_directive[3]
    output logic m_tvalid,
    input  logic m_tready,
    output logic m_tlast          // last_of_run
);
    import cst_pkg::*;

    localparam int DATA_W = ((OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8;
    localparam int SPW    = ((OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS) + 1;
    localparam int TOK_W  = 3 + OFFSET_BITS + LENGTH_BITS + 1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

    typedef struct packed {
        logic                   ends;
        logic [LENGTH_BITS-1:0] len;
        logic [OFFSET_BITS-1:0] start;
        logic [2:0]             kind;
    } tok_t;

    function automatic logic [LENGTH_BITS-1:0] span_incl(input logic [OFFSET_BITS-1:0] from_v,
                                                        input logic [OFFSET_BITS-1:0] to_v);
        logic [OFFSET_BITS-1:0] diff;
        logic [SPW-1:0]         d;
        diff = to_v - from_v;
        d    = SPW'(diff);
        if (d >= SPW'(LEN_MAX)) begin
            return LEN_MAX;
        end
        return LENGTH_BITS'(d + SPW'(1));
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LEN_ONE;
    endfunction

    logic [OFFSET_BITS-1:0] pos_reg,  pos_next;
    mode_t                  mode_reg, mode_next;
    kind_t                  kind_reg, kind_next;
    logic [OFFSET_BITS-1:0] ost_reg,  ost_next;
    logic [LENGTH_BITS-1:0] oln_reg,  oln_next;
    logic                   dm_reg,   dm_next;
    logic                   hw_reg,   hw_next;
    logic [OFFSET_BITS-1:0] hoff_reg, hoff_next;
    logic                   sw_reg,   sw_next;

    logic [7:0]             c;
    logic                   accept;
    logic [OFFSET_BITS-1:0] pos_prev;
    logic [OFFSET_BITS-1:0] pos_nxt;
    logic [LENGTH_BITS-1:0] span_here;
    logic [LENGTH_BITS-1:0] span_prev;
    logic [OFFSET_BITS-1:0] diff_end;
    logic [SPW-1:0]         ext_end;
    logic                   done;
    logic                   restart;
    tok_t [2:0]             res_tok;
    logic [1:0]             res_cnt;
    push_t                  push;
    logic                   can_load;
    tok_t                   out_tok;

    assign c         = s_tdata;
    assign accept    = s_tvalid && s_tready;
    assign pos_prev  = pos_reg - OFFSET_BITS'(1);
    assign pos_nxt   = pos_reg + OFFSET_BITS'(1);
    assign span_here = span_incl(hoff_reg, pos_reg);
    assign span_prev = span_incl(hoff_reg, pos_prev);

    always_comb begin
        pos_next  = pos_nxt;
        mode_next = mode_reg;
        kind_next = kind_reg;
        ost_next  = ost_reg;
        oln_next  = oln_reg;
        dm_next   = dm_reg;
        hw_next   = hw_reg;
        hoff_next = hoff_reg;
        sw_next   = sw_reg;
        res_tok   = '0;
        res_cnt   = 2'd0;
        done      = 1'b0;
        restart   = 1'b0;
        diff_end  = '0;
        ext_end   = '0;

        // resolve a held slash against this byte
        if (sw_next) begin
            sw_next = 1'b0;
            if (c == CH_SLASH) begin
                if (mode_next == MODE_RUN) begin
                    if (res_cnt != 2'd3) begin
                        res_tok[res_cnt] = '{ends: 1'b0, len: oln_next, start: ost_next,
                                             kind: kind_next};
                        res_cnt = res_cnt + 2'd1;
                    end
                end
                ost_next  = hw_next ? hoff_reg : pos_prev;
                oln_next  = sat_inc(hw_next ? span_prev : LEN_ONE);
                kind_next = KIND_COMMENT;
                mode_next = MODE_COMMENT;
                hw_next   = 1'b0;
                done      = 1'b1;
            end else if (mode_next == MODE_RUN) begin
                oln_next = sat_inc(oln_next);
            end else begin
                ost_next  = hw_next ? hoff_reg : pos_prev;
                oln_next  = hw_next ? span_prev : LEN_ONE;
                kind_next = KIND_DONT_CARE;
                mode_next = MODE_RUN;
                hw_next   = 1'b0;
            end
        end

        if (!done) begin
            unique case (mode_next)
                MODE_COMMENT: begin
                    if (c != CH_NL) begin
                        oln_next = sat_inc(oln_next);
                    end else begin
                        restart = 1'b1;
                    end
                end
                MODE_LITERAL: begin
                    if (c == CH_NL) begin
                        restart = 1'b1;
                    end else begin
                        oln_next = sat_inc(oln_next);
                        if (c == CH_QUOTE) begin
                            if (res_cnt != 2'd3) begin
                                res_tok[res_cnt] = '{ends: 1'b0, len: oln_next,
                                                     start: ost_next, kind: kind_next};
                                res_cnt = res_cnt + 2'd1;
                            end
                            mode_next = MODE_IDLE;
                            kind_next = KIND_END;
                            ost_next  = '0;
                            oln_next  = '0;
                        end
                    end
                end
                MODE_SYMBOL: begin
                    if (sym_more(c) || (dm_next && ((c == CH_DOT) || (c == CH_SLASH)))) begin
                        oln_next = sat_inc(oln_next);
                    end else begin
                        restart = 1'b1;
                    end
                end
                MODE_RUN: begin
                    if (in_run(c)) begin
                        if (c == CH_SLASH) begin
                            sw_next = 1'b1;
                        end else begin
                            oln_next = sat_inc(oln_next);
                        end
                    end else begin
                        restart = 1'b1;
                    end
                end
                MODE_IDLE: begin
                    restart = 1'b1;
                end
                default: begin
                    mode_next = MODE_IDLE;
                    restart   = 1'b1;
                end
            endcase

            // close the open token before starting on this byte
            if (restart && (mode_next != MODE_IDLE)) begin
                if (res_cnt != 2'd3) begin
                    res_tok[res_cnt] = '{ends: 1'b0, len: oln_next, start: ost_next,
                                         kind: kind_next};
                    res_cnt = res_cnt + 2'd1;
                end
                mode_next = MODE_IDLE;
                kind_next = KIND_END;
                ost_next  = '0;
                oln_next  = '0;
            end

            if (restart) begin
                priority if (is_blank(c)) begin
                    hw_next = hw_next;
                end else if (c == CH_NL) begin
                    if (res_cnt != 2'd3) begin
                        res_tok[res_cnt] = '{ends: dm_next,
                                             len: hw_next ? span_here : LEN_ONE,
                                             start: hw_next ? hoff_reg : pos_reg,
                                             kind: KIND_NEWLINE};
                        res_cnt = res_cnt + 2'd1;
                    end
                    hw_next = 1'b0;
                    dm_next = 1'b0;
                end else if (c == CH_HASH) begin
                    if (!hw_next) begin
                        hw_next   = 1'b1;
                        hoff_next = pos_reg;
                    end
                    dm_next = 1'b1;
                end else if (c == CH_SLASH) begin
                    sw_next = 1'b1;
                end else if (dm_next && ((c == CH_GT) || (c == CH_QUOTE))) begin
                    if (res_cnt != 2'd3) begin
                        res_tok[res_cnt] = '{ends: 1'b0,
                                             len: hw_next ? span_here : LEN_ONE,
                                             start: hw_next ? hoff_reg : pos_reg,
                                             kind: KIND_DONT_CARE};
                        res_cnt = res_cnt + 2'd1;
                    end
                    hw_next = 1'b0;
                end else if ((c == CH_QUOTE) || sym_first(c) || in_run(c)) begin
                    ost_next = hw_next ? hoff_reg : pos_reg;
                    oln_next = hw_next ? span_here : LEN_ONE;
                    hw_next  = 1'b0;
                    if (c == CH_QUOTE) begin
                        kind_next = KIND_LITERAL;
                        mode_next = MODE_LITERAL;
                    end else if (sym_first(c)) begin
                        kind_next = KIND_SYMBOL;
                        mode_next = MODE_SYMBOL;
                    end else begin
                        kind_next = is_digit(c) ? KIND_INTEGER : KIND_DONT_CARE;
                        mode_next = MODE_RUN;
                    end
                end else begin
                    if (res_cnt != 2'd3) begin
                        res_tok[res_cnt] = '{ends: 1'b0,
                                             len: hw_next ? span_here : LEN_ONE,
                                             start: hw_next ? hoff_reg : pos_reg,
                                             kind: KIND_INVALID};
                        res_cnt = res_cnt + 2'd1;
                    end
                    hw_next = 1'b0;
                end
            end
        end

        // flush on the final byte
        if (s_tlast) begin
            if (sw_next) begin
                sw_next = 1'b0;
                if (mode_next == MODE_RUN) begin
                    oln_next = sat_inc(oln_next);
                end else begin
                    ost_next  = hw_next ? hoff_reg : pos_reg;
                    oln_next  = hw_next ? span_here : LEN_ONE;
                    kind_next = KIND_DONT_CARE;
                    mode_next = MODE_RUN;
                    hw_next   = 1'b0;
                end
            end
            if (mode_next != MODE_IDLE) begin
                if (res_cnt != 2'd3) begin
                    res_tok[res_cnt] = '{ends: 1'b0, len: oln_next, start: ost_next,
                                         kind: kind_next};
                    res_cnt = res_cnt + 2'd1;
                end
            end
            diff_end = pos_nxt - hoff_next;
            ext_end  = SPW'(diff_end);
            if (res_cnt != 2'd3) begin
                if (hw_next) begin
                    res_tok[res_cnt] = '{ends: 1'b0,
                                         len: (ext_end > SPW'(LEN_MAX)) ? LEN_MAX
                                                                        : LENGTH_BITS'(ext_end),
                                         start: hoff_next, kind: KIND_END};
                end else begin
                    res_tok[res_cnt] = '{ends: 1'b0, len: '0, start: pos_nxt, kind: KIND_END};
                end
                res_cnt = res_cnt + 2'd1;
            end
            pos_next  = '0;
            mode_next = MODE_IDLE;
            kind_next = KIND_END;
            ost_next  = '0;
            oln_next  = '0;
            dm_next   = 1'b0;
            hw_next   = 1'b0;
            hoff_next = '0;
            sw_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            mode_reg <= MODE_IDLE;
            dm_reg   <= 1'b0;
            hw_reg   <= 1'b0;
            sw_reg   <= 1'b0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            dm_reg   <= dm_next;
            hw_reg   <= hw_next;
            sw_reg   <= sw_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kind_next;
            ost_reg  <= ost_next;
            oln_reg  <= oln_next;
            hoff_reg <= hoff_next;
        end
    end

    assign push.load  = accept;
    assign push.count = res_cnt;
    assign s_tready   = can_load;

    cst_res_buf #(
        .TOK_W(TOK_W)
    ) u_res_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (res_tok),
        .can_load (can_load),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_tok  (out_tok),
        .out_last (m_tlast)
    );

    assign m_tdata = DATA_W'({out_tok.len, out_tok.start});
    assign m_tuser = {out_tok.ends, out_tok.kind};

endmodule

// ----- rtl/core/cst_checker.sv -----
module cst_checker #(
    parameter int LENGTH_BITS = cst_pkg::CST_LENGTH_BITS,
    parameter int OFFSET_BITS = cst_pkg::CST_OFFSET_BITS
) (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic s_tlast,
    input logic [((OFFSET_BITS+LENGTH_BITS+7)/8)*8-1:0] m_tdata,
    input logic [3:0] m_tuser,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);
    import cst_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    a_final_gives_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final byte produced no token");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == KIND_END) |-> m_tlast)
        else $error("end token not last of its run");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a run is still draining");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind c_source_tokenizer_unit cst_checker #(
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
) u_cst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast (s_tlast),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tlast (m_tlast)
);
